>>> rtl/spi_ethernet_rx_deframer_core_assert.svh
// assertion macros for the spi ethernet receive deframer
// used by spi_ethernet_rx_deframer_core.sv; needs no other file
`ifndef SPI_ETHERNET_RX_DEFRAMER_CORE_ASSERT_SVH
`define SPI_ETHERNET_RX_DEFRAMER_CORE_ASSERT_SVH

// same-cycle implication, disabled during reset
`define SPI_ERX_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("spi_erx assertion failed");

// next-cycle implication, disabled during reset
`define SPI_ERX_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("spi_erx assertion failed");

`endif

>>> rtl/spi_erx_pkg.sv
// constants and field widths for the spi ethernet receive deframer
// no dependencies; imported by spi_ethernet_rx_deframer_core
`timescale 1ns / 1ps
`default_nettype none

package spi_erx_pkg;

  // frame limits and magic values
  localparam int          MAX_PAYLOAD   = 2048;
  localparam logic [7:0]  START_BYTE    = 8'hAA;
  localparam logic [15:0] ETYPE_HOMEPLUG = 16'h88E1;
  localparam logic [15:0] ETYPE_IPV6    = 16'h86DD;
  localparam int          HDR_OVERHEAD  = 10;
  localparam int          MIN_CLASSIFY  = 14;

  // field widths
  localparam int BYTE_W   = 8;
  localparam int COUNT_W  = 12;
  localparam int LEN_W    = 16;

  // packed stream widths
  localparam int IN_TDATA_W  = 24;
  localparam int IN_TUSER_W  = 1;
  localparam int OUT_TDATA_W = 8;
  localparam int OUT_TUSER_W = 5;

  // ether class codes
  localparam logic [1:0] ECLS_HOMEPLUG = 2'd0;
  localparam logic [1:0] ECLS_IPV6     = 2'd1;
  localparam logic [1:0] ECLS_OTHER    = 2'd2;

  // frame status codes
  localparam logic [1:0] STAT_OK     = 2'd0;
  localparam logic [1:0] STAT_TRUNC  = 2'd1;
  localparam logic [1:0] STAT_REJECT = 2'd2;
  localparam logic [1:0] STAT_CUT    = 2'd3;

endpackage : spi_erx_pkg

`default_nettype wire

>>> rtl/spi_ethernet_rx_deframer_core.sv
// spi ethernet receive deframer: byte-serial parser with a registered result stage
// depends on spi_erx_pkg and spi_ethernet_rx_deframer_core_assert.svh
`timescale 1ns / 1ps
`default_nettype none

// Takes a modem read burst one byte per request on the in_ stream and gives the
// payload bytes of each frame on the out_ stream, with frame_end on tlast and the
// ether class and status in tuser. One byte is taken every clock cycle: the parser
// state updates in one step per byte and the result sits in a single output
// register, so a new byte is accepted while the previous result is still waiting,
// and input stalls only while that register is full and out_tready is low. A byte
// that yields no result is consumed without producing an output request.
module spi_ethernet_rx_deframer_core (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_tvalid,
  output logic                                     in_tready,
  // [7:0] rx_byte, [19:8] avail_count, [23:20] zero
  input  wire logic [spi_erx_pkg::IN_TDATA_W-1:0]  in_tdata,
  // [0] burst_start
  input  wire logic [spi_erx_pkg::IN_TUSER_W-1:0]  in_tuser,
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  // [7:0] payload_byte
  output logic [spi_erx_pkg::OUT_TDATA_W-1:0]      out_tdata,
  // [0] has_byte, [2:1] ether_class, [4:3] status
  output logic [spi_erx_pkg::OUT_TUSER_W-1:0]      out_tuser,
  // frame_end
  output logic                                     out_tlast
);

  import spi_erx_pkg::*;

  `include "spi_ethernet_rx_deframer_core_assert.svh"

  // parser phase codes
  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_FRAME = 2'd1;
  localparam logic [1:0] PH_DONE  = 2'd2;

  localparam logic [12:0] MAXP_13  = 13'(MAX_PAYLOAD);
  localparam logic [16:0] MAXP_17  = 17'(MAX_PAYLOAD);
  localparam logic [16:0] OVHD_17  = 17'(HDR_OVERHEAD);
  localparam logic [15:0] MINC_16  = 16'(MIN_CLASSIFY);

  // parser state
  logic [1:0]         phase_r, phase_nxt;
  logic [COUNT_W-1:0] rem_r, rem_nxt;
  logic [COUNT_W-1:0] pos_r, pos_nxt;
  logic [LEN_W-1:0]   outer_r, outer_nxt;
  logic [LEN_W-1:0]   inner_r, inner_nxt;
  logic [LEN_W-1:0]   etype_r, etype_nxt;
  logic               sok_r, sok_nxt;

  // result register
  logic               ovalid_r, ovalid_nxt;
  logic [BYTE_W-1:0]  opb_r, opb_nxt;
  logic               ohb_r, ohb_nxt;
  logic               ofe_r, ofe_nxt;
  logic [1:0]         oec_r, oec_nxt;
  logic [1:0]         ost_r, ost_nxt;

  // step outcome
  logic               in_fire;
  logic               emit;
  logic               reject;
  logic [BYTE_W-1:0]  rx_byte;
  logic               burst_start;
  logic [COUNT_W-1:0] avail;

  assign in_tready   = !ovalid_r || out_tready;
  assign in_fire     = in_tvalid && in_tready;
  assign rx_byte     = in_tdata[7:0];
  assign avail       = in_tdata[19:8];
  assign burst_start = in_tuser[0];

  // per-byte parser step
  always_comb begin
    logic [COUNT_W-1:0] p;
    logic [COUNT_W-1:0] rem_dec;
    logic [COUNT_W-1:0] idx;
    logic [16:0]        pp;
    logic [16:0]        lpp;
    logic [15:0]        inner_hi;
    logic               in_payload;
    phase_nxt  = phase_r;
    rem_nxt    = rem_r;
    pos_nxt    = pos_r;
    outer_nxt  = outer_r;
    inner_nxt  = inner_r;
    etype_nxt  = etype_r;
    sok_nxt    = sok_r;
    emit       = 1'b0;
    reject     = 1'b0;
    opb_nxt    = '0;
    ohb_nxt    = 1'b0;
    ofe_nxt    = 1'b0;
    oec_nxt    = '0;
    ost_nxt    = '0;
    p          = '0;
    rem_dec    = '0;
    idx        = '0;
    pp         = '0;
    lpp        = '0;
    inner_hi   = '0;
    in_payload = 1'b0;

    // burst start restarts the parser
    if (burst_start) begin
      phase_nxt = (avail != '0) ? PH_FRAME : PH_IDLE;
      rem_nxt   = avail;
      pos_nxt   = '0;
      outer_nxt = '0;
      inner_nxt = '0;
      etype_nxt = '0;
      sok_nxt   = 1'b1;
    end

    if (phase_nxt == PH_FRAME) begin
      if (rem_nxt == '0) begin
        phase_nxt = PH_DONE;
      end else begin
        rem_dec  = rem_nxt - 1'b1;
        rem_nxt  = rem_dec;
        p        = pos_nxt;
        pp       = {5'd0, p};
        lpp      = 17'd11 + {1'b0, inner_nxt};
        inner_hi = {rx_byte, inner_nxt[7:0]};

        // header fields
        if (p == 12'd2) begin
          outer_nxt = {rx_byte, 8'd0};
        end else if (p == 12'd3) begin
          outer_nxt = {outer_nxt[15:8], rx_byte};
        end else if (p inside {[12'd4:12'd7]}) begin
          if (rx_byte != START_BYTE) sok_nxt = 1'b0;
        end else if (p == 12'd8) begin
          inner_nxt = {8'd0, rx_byte};
        end else if (p == 12'd9) begin
          inner_nxt = inner_hi;
          if (!sok_nxt || ({1'b0, inner_hi} + OVHD_17) != {1'b0, outer_nxt}) begin
            reject = 1'b1;
          end
        end else if (p >= 12'd12 && pp <= lpp) begin
          in_payload = 1'b1;
        end

        // payload bytes and ether type capture
        if (in_payload) begin
          idx = p - 12'd12;
          if (idx == 12'd12) etype_nxt = {rx_byte, 8'd0};
          else if (idx == 12'd13) etype_nxt = {etype_nxt[15:8], rx_byte};
          if ({1'b0, idx} < MAXP_13) begin
            opb_nxt = rx_byte;
            ohb_nxt = 1'b1;
            emit    = 1'b1;
          end
        end

        if (reject) begin
          // header rejected: report and ignore rest of burst
          emit      = 1'b1;
          opb_nxt   = '0;
          ohb_nxt   = 1'b0;
          ofe_nxt   = 1'b1;
          oec_nxt   = ECLS_OTHER;
          ost_nxt   = STAT_REJECT;
          phase_nxt = PH_DONE;
        end else begin
          // frame end or burst cut short
          if (p >= 12'd11 && pp == lpp) begin
            emit    = 1'b1;
            ofe_nxt = 1'b1;
            if (inner_nxt < MINC_16) oec_nxt = ECLS_OTHER;
            else if (etype_nxt == ETYPE_HOMEPLUG) oec_nxt = ECLS_HOMEPLUG;
            else if (etype_nxt == ETYPE_IPV6) oec_nxt = ECLS_IPV6;
            else oec_nxt = ECLS_OTHER;
            ost_nxt = ({1'b0, inner_nxt} > MAXP_17) ? STAT_TRUNC : STAT_OK;
          end else if (rem_dec == '0 && (p < 12'd10 || pp < lpp)) begin
            emit    = 1'b1;
            ofe_nxt = 1'b1;
            oec_nxt = ECLS_OTHER;
            ost_nxt = STAT_CUT;
          end

          // last footer byte: next frame or done
          if (p >= 12'd10 && pp == lpp + 17'd2) begin
            if (rem_dec > 12'd10) begin
              pos_nxt   = '0;
              outer_nxt = '0;
              inner_nxt = '0;
              etype_nxt = '0;
              sok_nxt   = 1'b1;
            end else begin
              phase_nxt = PH_DONE;
            end
          end else begin
            pos_nxt = p + 1'b1;
          end
          if (rem_dec == '0) phase_nxt = PH_DONE;
        end
      end
    end
  end

  // output register load or drain
  always_comb begin
    ovalid_nxt = ovalid_r;
    if (in_tready) ovalid_nxt = in_fire && emit;
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_IDLE;
      rem_r    <= '0;
      pos_r    <= '0;
      outer_r  <= '0;
      inner_r  <= '0;
      etype_r  <= '0;
      sok_r    <= 1'b1;
      ovalid_r <= 1'b0;
    end else begin
      ovalid_r <= ovalid_nxt;
      if (in_fire) begin
        phase_r <= phase_nxt;
        rem_r   <= rem_nxt;
        pos_r   <= pos_nxt;
        outer_r <= outer_nxt;
        inner_r <= inner_nxt;
        etype_r <= etype_nxt;
        sok_r   <= sok_nxt;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (in_fire && emit) begin
      opb_r <= opb_nxt;
      ohb_r <= ohb_nxt;
      ofe_r <= ofe_nxt;
      oec_r <= oec_nxt;
      ost_r <= ost_nxt;
    end
  end

  assign out_tvalid = ovalid_r;
  assign out_tdata  = opb_r;
  assign out_tuser  = {ost_r, oec_r, ohb_r};
  assign out_tlast  = ofe_r;

  // checks
  `SPI_ERX_ASSERT_NEXT(a_emit_loads, clk, rst_n, in_fire && emit, ovalid_r)
  `SPI_ERX_ASSERT_NEXT(a_reject_done, clk, rst_n, in_fire && reject, phase_r == PH_DONE)
  `SPI_ERX_ASSERT_NEXT(a_done_stays, clk, rst_n,
    in_fire && !burst_start && phase_r == PH_DONE, phase_r == PH_DONE)
  `SPI_ERX_ASSERT_NOW(a_frame_has_bytes, clk, rst_n, phase_r == PH_FRAME, rem_r != '0)
  `SPI_ERX_ASSERT_NOW(a_reject_no_byte, clk, rst_n,
    ovalid_r && ofe_r && ost_r == STAT_REJECT, !ohb_r && oec_r == ECLS_OTHER)

endmodule : spi_ethernet_rx_deframer_core

`default_nettype wire

>>> dv/tb_top.sv
// testbench for spi_ethernet_rx_deframer_core: drives read bursts on the input stream
// and checks every output request against a behavioural model of the deframer
// depends on spi_erx_pkg and the rtl of the core
`timescale 1ns / 1ps

module tb_top;
  import spi_erx_pkg::*;

  localparam int CYCLE_LIMIT = 500000;
  localparam int DRAIN_CYCLES = 20;
  localparam int HOLD_CYCLES = 400;

  // byte positions inside one frame
  localparam int OUTER_HI_POS = 2;
  localparam int OUTER_LO_POS = 3;
  localparam int MAGIC_FIRST_POS = 4;
  localparam int MAGIC_LAST_POS = 7;
  localparam int INNER_LO_POS = 8;
  localparam int INNER_HI_POS = 9;
  localparam int RSVD_POS = 10;
  localparam int RSVD_END_POS = 11;
  localparam int PAYLOAD_POS = 12;
  localparam int FOOTER_LEN = 2;
  // payload indexes of the ethertype
  localparam int ETYPE_HI_IDX = 12;
  localparam int ETYPE_LO_IDX = 13;

  typedef enum logic [1:0] {
    PARSE_IDLE,
    PARSE_FRAME,
    PARSE_DONE
  } parse_phase_t;

  typedef enum int {
    FAULT_NONE,
    FAULT_START,
    FAULT_LENGTH
  } frame_fault_t;

  typedef struct packed {
    logic [7:0] payload;
    logic       has_byte;
    logic       frame_end;
    logic [1:0] eclass;
    logic [1:0] status;
  } frame_out_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic [IN_TUSER_W-1:0]  in_tuser = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [OUT_TUSER_W-1:0] out_tuser;
  logic                   out_tlast;

  // idling controls, written by the test sequence
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  logic        rx_hold = 1'b0;

  int unsigned error_count = 0;
  int unsigned bytes_sent = 0;
  int unsigned cycle_count = 0;

  frame_out_t  frame_out_q[$];
  logic [7:0]  burst_q[$];

  // deframer model state
  parse_phase_t prs_phase = PARSE_IDLE;
  logic [12:0]  prs_left = '0;
  logic [15:0]  prs_pos = '0;
  logic [15:0]  prs_outer = '0;
  logic [15:0]  prs_inner = '0;
  logic [15:0]  prs_etype = '0;
  logic         prs_start_ok = 1'b1;

  spi_ethernet_rx_deframer_core u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  // clock
  always #5 clk = ~clk;

  // run guard
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // receiver: random stalls plus an optional long hold-off
  always @(posedge clk) begin
    out_tready <= !rx_hold && ($urandom_range(0, 99) >= recv_stall_pct);
  end

  task automatic report_error(input string msg);
    error_count++;
    $display("ERROR @%0t: %s", $time, msg);
  endtask

  function automatic void restart_frame();
    prs_pos = '0;
    prs_outer = '0;
    prs_inner = '0;
    prs_etype = '0;
    prs_start_ok = 1'b1;
  endfunction

  // model of one accepted byte; returns 1 when the byte yields a result
  function automatic bit deframe_byte(input logic [7:0] b, input logic start,
                                      input logic [11:0] avail, output frame_out_t res);
    int unsigned p;
    int unsigned last_pos;
    int unsigned idx;
    bit emit;
    res = '0;
    emit = 1'b0;
    if (start) begin
      restart_frame();
      prs_left = 13'(avail);
      prs_phase = (avail != 0) ? PARSE_FRAME : PARSE_IDLE;
    end
    if (prs_phase != PARSE_FRAME) return 1'b0;
    if (prs_left == 0) begin
      prs_phase = PARSE_DONE;
      return 1'b0;
    end
    prs_left = prs_left - 1'b1;
    p = prs_pos;
    last_pos = RSVD_END_POS + prs_inner;

    // header fields and payload
    if (p == OUTER_HI_POS) begin
      prs_outer = {b, 8'h00};
    end else if (p == OUTER_LO_POS) begin
      prs_outer = prs_outer | {8'h00, b};
    end else if (p >= MAGIC_FIRST_POS && p <= MAGIC_LAST_POS) begin
      if (b != START_BYTE) prs_start_ok = 1'b0;
    end else if (p == INNER_LO_POS) begin
      prs_inner = {8'h00, b};
    end else if (p == INNER_HI_POS) begin
      prs_inner = prs_inner | {b, 8'h00};
      if (!prs_start_ok || (int'(prs_inner) + HDR_OVERHEAD != int'(prs_outer))) begin
        res.frame_end = 1'b1;
        res.eclass = ECLS_OTHER;
        res.status = STAT_REJECT;
        prs_phase = PARSE_DONE;
        return 1'b1;
      end
    end else if (p >= PAYLOAD_POS && p <= last_pos) begin
      idx = p - PAYLOAD_POS;
      if (idx == ETYPE_HI_IDX) prs_etype = {b, 8'h00};
      else if (idx == ETYPE_LO_IDX) prs_etype = prs_etype | {8'h00, b};
      if (idx < MAX_PAYLOAD) begin
        res.payload = b;
        res.has_byte = 1'b1;
        emit = 1'b1;
      end
    end

    // frame end, or the burst running out before it
    if (p >= RSVD_END_POS && p == last_pos) begin
      emit = 1'b1;
      res.frame_end = 1'b1;
      if (prs_inner < MIN_CLASSIFY) res.eclass = ECLS_OTHER;
      else if (prs_etype == ETYPE_HOMEPLUG) res.eclass = ECLS_HOMEPLUG;
      else if (prs_etype == ETYPE_IPV6) res.eclass = ECLS_IPV6;
      else res.eclass = ECLS_OTHER;
      res.status = (prs_inner > MAX_PAYLOAD) ? STAT_TRUNC : STAT_OK;
    end else if (prs_left == 0 && (p < RSVD_POS || p < last_pos)) begin
      emit = 1'b1;
      res.frame_end = 1'b1;
      res.eclass = ECLS_OTHER;
      res.status = STAT_CUT;
    end

    // after the footer a further frame needs more than a header's worth of bytes
    if (p >= RSVD_POS && p == last_pos + FOOTER_LEN) begin
      if (prs_left > HDR_OVERHEAD) restart_frame();
      else prs_phase = PARSE_DONE;
    end else begin
      prs_pos = 16'(p + 1);
    end
    if (prs_left == 0) prs_phase = PARSE_DONE;
    return emit;
  endfunction

  task automatic check_result();
    frame_out_t want;
    if (frame_out_q.size() == 0) begin
      report_error($sformatf("unexpected result: data %02h user %02h last %0b",
                             out_tdata, out_tuser, out_tlast));
      return;
    end
    want = frame_out_q.pop_front();
    if (out_tdata !== want.payload)
      report_error($sformatf("payload byte: got %02h, want %02h", out_tdata, want.payload));
    if (out_tuser[0] !== want.has_byte)
      report_error($sformatf("has_byte: got %0b, want %0b", out_tuser[0], want.has_byte));
    if (out_tlast !== want.frame_end)
      report_error($sformatf("frame_end: got %0b, want %0b", out_tlast, want.frame_end));
    if (out_tuser[2:1] !== want.eclass)
      report_error($sformatf("ether_class: got %0d, want %0d", out_tuser[2:1], want.eclass));
    if (out_tuser[4:3] !== want.status)
      report_error($sformatf("status: got %0d, want %0d", out_tuser[4:3], want.status));
  endtask

  // check each output request, then predict from each input request
  always @(posedge clk) begin
    frame_out_t pred;
    if (rst_n) begin
      if (out_tvalid && out_tready) check_result();
      if (in_tvalid && in_tready) begin
        if (deframe_byte(in_tdata[7:0], in_tuser[0], in_tdata[19:8], pred))
          frame_out_q.push_back(pred);
      end
    end
  end

  // offer one byte and wait until it is taken
  task automatic send_byte(input logic [7:0] b, input logic start, input logic [11:0] avail);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {4'd0, avail, b};
    in_tuser <= start;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    bytes_sent++;
  endtask

  // append one frame to the burst buffer
  function automatic void add_frame(input int unsigned plen, input frame_fault_t fault,
                                    input logic [15:0] etype);
    logic [15:0] outer;
    logic [15:0] inner;
    logic [7:0]  bad;
    int unsigned bad_pos;
    inner = 16'(plen);
    outer = 16'(plen + HDR_OVERHEAD);
    if (fault == FAULT_LENGTH) outer = outer ^ 16'($urandom_range(1, 65535));
    bad_pos = $urandom_range(MAGIC_FIRST_POS, MAGIC_LAST_POS);
    bad = 8'($urandom_range(0, 254));
    if (bad == START_BYTE) bad = 8'hFF;
    // upper outer-length bytes are not used
    burst_q.push_back(8'($urandom));
    burst_q.push_back(8'($urandom));
    burst_q.push_back(outer[15:8]);
    burst_q.push_back(outer[7:0]);
    for (int i = MAGIC_FIRST_POS; i <= MAGIC_LAST_POS; i++)
      burst_q.push_back((fault == FAULT_START && i == bad_pos) ? bad : START_BYTE);
    burst_q.push_back(inner[7:0]);
    burst_q.push_back(inner[15:8]);
    burst_q.push_back(8'($urandom));
    burst_q.push_back(8'($urandom));
    for (int unsigned i = 0; i < plen; i++) begin
      if (i == ETYPE_HI_IDX) burst_q.push_back(etype[15:8]);
      else if (i == ETYPE_LO_IDX) burst_q.push_back(etype[7:0]);
      else burst_q.push_back(8'($urandom));
    end
    burst_q.push_back(8'($urandom));
    burst_q.push_back(8'($urandom));
  endfunction

  // send count bytes of the burst buffer (random filler past its end)
  task automatic send_burst(input int unsigned avail, input int unsigned count);
    for (int unsigned i = 0; i < count; i++)
      send_byte((i < burst_q.size()) ? burst_q[i] : 8'($urandom), i == 0,
                (i == 0) ? 12'(avail) : 12'($urandom));
  endtask

  // stop offering, then wait until every predicted result has come out
  task automatic wait_drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (frame_out_q.size() != 0) @(posedge clk);
  endtask

  // one random burst of one to three frames with a random length field
  task automatic send_random_burst();
    int unsigned nframes;
    int unsigned plen;
    int unsigned pick;
    int unsigned avail;
    int unsigned count;
    int unsigned size;
    frame_fault_t fault;
    logic [15:0] etype;
    burst_q.delete();
    nframes = $urandom_range(1, 3);
    repeat (nframes) begin
      pick = $urandom_range(0, 19);
      if (pick == 0) plen = $urandom_range(0, 13);
      else if (pick == 1) plen = $urandom_range(100, 300);
      else plen = $urandom_range(14, 48);
      pick = $urandom_range(0, 19);
      fault = (pick == 0) ? FAULT_START : (pick == 1) ? FAULT_LENGTH : FAULT_NONE;
      pick = $urandom_range(0, 99);
      if (pick < 40) etype = ETYPE_HOMEPLUG;
      else if (pick < 70) etype = ETYPE_IPV6;
      else etype = 16'($urandom);
      add_frame(plen, fault, etype);
    end
    size = burst_q.size();
    pick = $urandom_range(0, 99);
    if (pick < 55) begin
      // exact length, sometimes with stray bytes after it
      avail = size;
      count = size + (($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0);
    end else if (pick < 70) begin
      // burst ends early
      avail = $urandom_range(1, size);
      count = avail + $urandom_range(0, 3);
    end else if (pick < 80) begin
      // short tail, too small for another frame
      avail = size + $urandom_range(1, HDR_OVERHEAD);
      count = avail;
    end else if (pick < 88) begin
      // tail long enough to start parsing junk as a frame
      avail = size + $urandom_range(HDR_OVERHEAD + 1, 40);
      count = avail;
    end else begin
      // burst claims more; the next burst start cuts it off
      avail = size + $urandom_range(1, 200);
      count = size + $urandom_range(0, 5);
    end
    if (avail > 4095) avail = 4095;
    send_burst(avail, count);
  endtask

  task automatic test_special_cases();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    // empty burst, then a stray byte while idle
    send_byte(8'h5A, 1'b1, 12'd0);
    send_byte(8'hFF, 1'b0, 12'hFFF);
    // bad start byte, burst ending on the rejecting byte, then a stray byte
    burst_q.delete();
    add_frame(0, FAULT_START, 16'h0000);
    send_burst(10, 10);
    send_byte(8'h00, 1'b0, 12'h000);
    // empty payload, burst ends in the footer
    burst_q.delete();
    add_frame(0, FAULT_NONE, 16'h0000);
    send_burst(burst_q.size(), burst_q.size());
    // burst ends inside the header
    burst_q.delete();
    add_frame(20, FAULT_NONE, ETYPE_IPV6);
    send_burst(5, 5);
    // outer and inner lengths disagree
    burst_q.delete();
    add_frame(3, FAULT_LENGTH, 16'h0000);
    send_burst(burst_q.size(), 10);
    wait_drain();
  endtask

  task automatic test_truncated_frame();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    burst_q.delete();
    add_frame(MAX_PAYLOAD + 1, FAULT_NONE, ETYPE_HOMEPLUG);
    send_burst(burst_q.size(), burst_q.size());
    wait_drain();
  endtask

  task automatic test_random_bursts(input int unsigned n_items, input int unsigned idle,
                                    input int unsigned stall);
    int unsigned target;
    send_idle_pct = idle;
    recv_stall_pct = stall;
    target = bytes_sent + n_items;
    while (bytes_sent < target) begin
      case ($urandom_range(0, 19))
        0: send_byte(8'($urandom), 1'b0, 12'($urandom));
        1: send_byte(8'($urandom), 1'b1, 12'd0);
        default: send_random_burst();
      endcase
    end
    wait_drain();
  endtask

  task automatic test_output_backpressure();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    burst_q.delete();
    repeat (3) add_frame(30, FAULT_NONE, ETYPE_HOMEPLUG);
    // hold the receiver off while the sender keeps offering bytes
    fork
      begin
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        rx_hold <= 1'b0;
      end
    join_none
    send_burst(burst_q.size(), burst_q.size());
    wait_drain();
  endtask

  // test sequence
  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_special_cases();
    test_truncated_frame();
    test_random_bursts(240, 0, 0);
    test_random_bursts(240, 86, 0);
    test_random_bursts(240, 0, 86);
    test_random_bursts(240, 35, 35);
    test_output_backpressure();
    wait_drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (frame_out_q.size() != 0) report_error("results still expected at the end");
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

>>> spi_ethernet_rx_deframer_core.f
+incdir+rtl
rtl/spi_erx_pkg.sv
rtl/spi_ethernet_rx_deframer_core.sv
dv/tb_top.sv
